// ===== hw/rtl/ldg_pkg.sv =====
// ----------------------------------------------------------------------------
// ldg_pkg
// Shared widths, constants, codes and interface types of the load-based
// DVFS governor.
// ----------------------------------------------------------------------------
`default_nettype none

package ldg_pkg;

	// Field widths
	localparam int FreqW  = 22;
	localparam int TimeW  = 64;
	localparam int DwellW = 32;
	localparam int ModeW  = 3;
	localparam int RunW   = 8;
	localparam int ActW   = 2;
	localparam int LoadW  = 7;
	localparam int StepW  = 2;

	// Load datapath widths: ten times a remainder below 2^64, cur times load
	localparam int RemW       = TimeW + 4;
	localparam int ProdW      = FreqW + LoadW;
	localparam int RecipW     = 30;
	localparam int RecipShift = 36;
	localparam int ScaleW     = ProdW + RecipW;

	// APB register file
	localparam int AddrW = 5;
	localparam int DataW = 32;

	// Frequencies and limits
	localparam logic [FreqW-1:0]  GuardKhz      = FreqW'(400000);
	localparam logic [FreqW-1:0]  MaxResetKhz   = FreqW'(1000000);
	localparam logic [FreqW-1:0]  MinResetKhz   = FreqW'(100000);
	localparam logic [FreqW-1:0]  ThrResetKhz   = FreqW'(1000000);
	localparam logic [FreqW-1:0]  SuspResetKhz  = FreqW'(400000);
	localparam logic [FreqW-1:0]  ResResetKhz   = FreqW'(800000);
	localparam logic [DwellW-1:0] DwellResetUs  = DwellW'(44000);
	localparam logic [LoadW-1:0]  FullLoad      = LoadW'(100);
	// ceil(2^36 / 100): exact quotient by 100 for any product below 2^30
	localparam logic [RecipW-1:0] RecipHundred  = RecipW'(687194768);
	localparam logic [StepW-1:0]  TopStep       = StepW'(3);

	typedef enum logic [ModeW-1:0] {
		MODE_IDLE_EXIT = 3'd0,
		MODE_SAMPLE    = 3'd1,
		MODE_WORK      = 3'd2,
		MODE_SUSPEND   = 3'd3,
		MODE_LIMITS    = 3'd4
	} mode_t;

	typedef enum logic [ActW-1:0] {
		ACT_NONE = 2'd0,
		ACT_UP   = 2'd1,
		ACT_DOWN = 2'd2,
		ACT_SET  = 2'd3
	} action_t;

	typedef enum logic {
		REL_CEIL  = 1'b0,
		REL_FLOOR = 1'b1
	} rel_t;

	typedef enum logic [2:0] {
		REG_MAX   = 3'd0,
		REG_MIN   = 3'd1,
		REG_THR   = 3'd2,
		REG_SUSP  = 3'd3,
		REG_RES   = 3'd4,
		REG_DWELL = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [FreqW-1:0]  max_khz;
		logic [FreqW-1:0]  min_khz;
		logic [FreqW-1:0]  thr_khz;
		logic [FreqW-1:0]  susp_khz;
		logic [FreqW-1:0]  res_khz;
		logic [DwellW-1:0] dwell_us;
	} cfg_t;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_CHECK  = 9'b000000010,
		S_ELAP   = 9'b000000100,
		S_BUSY   = 9'b000001000,
		S_MUL10  = 9'b000010000,
		S_DIV    = 9'b000100000,
		S_PROD   = 9'b001000000,
		S_RECIP  = 9'b010000000,
		S_COMMIT = 9'b100000000
	} state_t;

	typedef struct packed {
		logic             capture;
		logic             elapse;
		logic             busy;
		logic             mul10;
		logic             div_step;
		logic [StepW-1:0] shift;
		logic             prod;
		logic             recip;
		logic             commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_load;
		logic full_load;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ldg_apb_regs.sv =====
// ----------------------------------------------------------------------------
// ldg_apb_regs
// APB configuration registers: frequency limits, suspend and resume
// frequencies, and the ramp-down dwell time.
// ----------------------------------------------------------------------------
`default_nettype none

module ldg_apb_regs import ldg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Write the addressed register at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_khz  <= MaxResetKhz;
			cfg_q.min_khz  <= MinResetKhz;
			cfg_q.thr_khz  <= ThrResetKhz;
			cfg_q.susp_khz <= SuspResetKhz;
			cfg_q.res_khz  <= ResResetKhz;
			cfg_q.dwell_us <= DwellResetUs;
		end else if (wr_en) begin
			case (idx)
				REG_MAX:   cfg_q.max_khz  <= pwdata[FreqW-1:0];
				REG_MIN:   cfg_q.min_khz  <= pwdata[FreqW-1:0];
				REG_THR:   cfg_q.thr_khz  <= pwdata[FreqW-1:0];
				REG_SUSP:  cfg_q.susp_khz <= pwdata[FreqW-1:0];
				REG_RES:   cfg_q.res_khz  <= pwdata[FreqW-1:0];
				REG_DWELL: cfg_q.dwell_us <= pwdata[DwellW-1:0];
				default: ;
			endcase
		end
	end

	// Return the addressed register, zero outside the map
	always_comb begin
		case (idx)
			REG_MAX:   prdata = DataW'(cfg_q.max_khz);
			REG_MIN:   prdata = DataW'(cfg_q.min_khz);
			REG_THR:   prdata = DataW'(cfg_q.thr_khz);
			REG_SUSP:  prdata = DataW'(cfg_q.susp_khz);
			REG_RES:   prdata = DataW'(cfg_q.res_khz);
			REG_DWELL: prdata = DataW'(cfg_q.dwell_us);
			default:   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ldg_ctrl.sv =====
// ----------------------------------------------------------------------------
// ldg_ctrl
// Sequencer of the governor: accepts a request, steps the load division
// when a work run needs it, and commits the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ldg_ctrl import ldg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire dp_status_t status,
	output ctrl_cmd_t       cmd
);

	state_t           state_q, state_d;
	logic [StepW-1:0] step_q;
	logic             digit_q;

	assign in_ready = (state_q == S_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.shift = step_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				state_d = status.need_load ? S_ELAP : S_COMMIT;
			end
			S_ELAP: begin
				cmd.elapse = 1'b1;
				state_d    = S_BUSY;
			end
			S_BUSY: begin
				cmd.busy = 1'b1;
				state_d  = status.full_load ? S_PROD : S_MUL10;
			end
			S_MUL10: begin
				cmd.mul10 = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) begin
					state_d = digit_q ? S_PROD : S_MUL10;
				end
			end
			S_PROD: begin
				cmd.prod = 1'b1;
				state_d  = S_RECIP;
			end
			S_RECIP: begin
				cmd.recip = 1'b1;
				state_d   = S_COMMIT;
			end
			S_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state, quotient bit step and decimal digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			digit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_BUSY) begin
				digit_q <= 1'b0;
			end
			if (state_q == S_MUL10) begin
				step_q <= TopStep;
			end else if (state_q == S_DIV) begin
				step_q <= step_q - StepW'(1);
				if (step_q == '0) begin
					digit_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ldg_dp.sv =====
// ----------------------------------------------------------------------------
// ldg_dp
// Governor datapath: request registers, governor state, event decision,
// load division and scaling, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ldg_dp import ldg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire ctrl_cmd_t        cmd,
	output dp_status_t            status,
	input  wire logic [ModeW-1:0] mode,
	input  wire logic [TimeW-1:0] idle_us,
	input  wire logic [TimeW-1:0] wall_us,
	input  wire logic [RunW-1:0]  runnable,
	input  wire logic [FreqW-1:0] cur_freq_khz,
	input  wire logic             suspend_flag,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [ActW-1:0]  action,
	output logic      [FreqW-1:0] freq_khz,
	output logic                  relation
);

	// Request registers
	logic [ModeW-1:0] mode_q;
	logic [TimeW-1:0] idle_q, wall_q;
	logic [RunW-1:0]  run_q;
	logic [FreqW-1:0] cur_q;
	logic             sflag_q;

	// Governor state
	logic [TimeW-1:0] idle_base_q, exit_wall_q, change_wall_q, change_idle_q;
	logic [FreqW-1:0] target_q;
	logic             ramp_seen_q, susp_q, pend_q;

	// Load computation
	logic [TimeW-1:0]  el_q, idl_q;
	logic [RemW-1:0]   rem_q;
	logic [LoadW-1:0]  load_q;
	logic [ProdW-1:0]  prod_q;
	logic [FreqW-1:0]  lf_q;

	// Result register
	logic             out_valid_q;
	logic [ActW-1:0]  act_q;
	logic [FreqW-1:0] freq_q;
	logic             rel_q;

	// Next-state values of the decision
	logic [TimeW-1:0] n_idle_base, n_exit_wall;
	logic [FreqW-1:0] n_target;
	logic             n_ramp, n_susp, n_pend, latch_change;
	logic             set_freq;
	action_t          o_act;
	logic [FreqW-1:0] o_freq;
	rel_t             o_rel;
	logic             full_path, susp_cap;
	logic [TimeW-1:0] since_change;
	logic [RemW-1:0]  div_sub;
	logic [ScaleW-1:0] scaled;

	assign full_path = !susp_q && ((target_q >= cfg.thr_khz) || (target_q == cfg.max_khz));
	assign susp_cap  = susp_q && (target_q > cfg.susp_khz);
	assign since_change = wall_q - change_wall_q;

	assign status.need_load = (mode_q == MODE_WORK) && pend_q && !full_path && !susp_cap;
	assign status.full_load = (el_q == '0) || (idl_q == '0);
	assign status.out_free  = !out_valid_q || out_ready;

	// Decide the event's state update and result
	always_comb begin
		n_idle_base  = idle_base_q;
		n_exit_wall  = exit_wall_q;
		n_target     = target_q;
		n_ramp       = ramp_seen_q;
		n_susp       = susp_q;
		n_pend       = pend_q;
		latch_change = 1'b0;
		set_freq     = 1'b0;
		o_act        = ACT_NONE;
		o_freq       = '0;
		o_rel        = REL_CEIL;
		case (mode_q)
			MODE_IDLE_EXIT: begin
				n_idle_base = idle_q;
				n_exit_wall = wall_q;
			end
			MODE_SAMPLE: begin
				if (wall_q != exit_wall_q) begin
					if (idle_q == idle_base_q) begin
						// No idle time since the latch: ramp up
						if ((cur_q != cfg.max_khz) && (run_q != '0)) begin
							if (cfg.max_khz > cfg.thr_khz) begin
								n_target = ramp_seen_q ? cfg.max_khz : cfg.thr_khz;
								n_ramp   = !ramp_seen_q;
							end else begin
								n_target = cfg.max_khz;
							end
							n_pend = 1'b1;
							o_act  = ACT_UP;
						end
					end else begin
						n_ramp = 1'b0;
						if (run_q != '0) begin
							n_idle_base = idle_q;
							n_exit_wall = wall_q;
						end
						if ((cur_q != cfg.min_khz) &&
							(since_change >= TimeW'(cfg.dwell_us))) begin
							n_target = cfg.min_khz;
							n_pend   = 1'b1;
							o_act    = ACT_DOWN;
						end
					end
				end
			end
			MODE_WORK: begin
				if (pend_q) begin
					n_pend = 1'b0;
					if (full_path) begin
						if (cur_q < GuardKhz) begin
							n_target = cfg.res_khz;
						end
						// Drop the up request on a lone task
						if (run_q != RunW'(1)) begin
							latch_change = 1'b1;
							set_freq     = 1'b1;
							o_freq       = cfg.max_khz;
							o_rel        = REL_FLOOR;
						end
					end else if (!susp_q) begin
						latch_change = 1'b1;
						n_target     = lf_q;
						set_freq     = 1'b1;
						o_freq       = lf_q;
					end else if (susp_cap) begin
						latch_change = 1'b1;
						set_freq     = 1'b1;
						o_freq       = cfg.susp_khz;
						o_rel        = REL_FLOOR;
					end else begin
						latch_change = 1'b1;
						n_target     = lf_q;
						if (lf_q < cur_q) begin
							set_freq = 1'b1;
							o_freq   = lf_q;
							o_rel    = REL_FLOOR;
						end
					end
				end
			end
			MODE_SUSPEND: begin
				n_susp   = sflag_q;
				set_freq = 1'b1;
				o_freq   = sflag_q ? cfg.susp_khz : cfg.res_khz;
				o_rel    = sflag_q ? REL_FLOOR : REL_CEIL;
			end
			MODE_LIMITS: begin
				if (cfg.max_khz < cur_q) begin
					set_freq = 1'b1;
					o_freq   = cfg.max_khz;
					o_rel    = REL_FLOOR;
				end else if (cfg.min_khz > cur_q) begin
					set_freq = 1'b1;
					o_freq   = cfg.min_khz;
				end
			end
			default: ;
		endcase
		if (set_freq) begin
			o_act = ACT_SET;
		end else begin
			o_freq = n_target;
			o_rel  = REL_CEIL;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q  <= mode;
			idle_q  <= idle_us;
			wall_q  <= wall_us;
			run_q   <= runnable;
			cur_q   <= cur_freq_khz;
			sflag_q <= suspend_flag;
		end
	end

	// Load: busy share of elapsed time, two decimal digits, then scale cur
	assign div_sub = RemW'(el_q) << cmd.shift;
	assign scaled  = ScaleW'(prod_q) * ScaleW'(RecipHundred);

	always_ff @(posedge clk) begin
		if (cmd.elapse) begin
			el_q  <= wall_q - change_wall_q;
			idl_q <= idle_q - change_idle_q;
		end
		if (cmd.busy) begin
			rem_q  <= (el_q > idl_q) ? RemW'(el_q - idl_q) : '0;
			load_q <= status.full_load ? FullLoad : '0;
		end else if (cmd.mul10) begin
			rem_q  <= (rem_q << 3) + (rem_q << 1);
			load_q <= (load_q << 3) + (load_q << 1);
		end else if (cmd.div_step) begin
			if (rem_q >= div_sub) begin
				rem_q  <= rem_q - div_sub;
				load_q <= load_q + (LoadW'(1) << cmd.shift);
			end
		end
		if (cmd.prod) begin
			prod_q <= ProdW'(cur_q) * ProdW'(load_q);
		end
		if (cmd.recip) begin
			lf_q <= scaled[RecipShift +: FreqW];
		end
	end

	// Commit the governor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_base_q   <= '0;
			exit_wall_q   <= '0;
			change_wall_q <= '0;
			change_idle_q <= '0;
			target_q      <= '0;
			ramp_seen_q   <= 1'b0;
			susp_q        <= 1'b0;
			pend_q        <= 1'b0;
		end else if (cmd.commit) begin
			idle_base_q <= n_idle_base;
			exit_wall_q <= n_exit_wall;
			target_q    <= n_target;
			ramp_seen_q <= n_ramp;
			susp_q      <= n_susp;
			pend_q      <= n_pend;
			if (latch_change) begin
				change_wall_q <= wall_q;
				change_idle_q <= idle_q;
			end
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			act_q  <= o_act;
			freq_q <= o_freq;
			rel_q  <= o_rel;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = act_q;
	assign freq_khz  = freq_q;
	assign relation  = rel_q;

endmodule

`default_nettype wire

// ===== hw/rtl/load_based_dvfs_governor_unit.sv =====
// ----------------------------------------------------------------------------
// load_based_dvfs_governor_unit
// Single-CPU load-based frequency governor: one action per event request.
// ----------------------------------------------------------------------------
// Each accepted request (idle exit, timer sample, work run, suspend/resume,
// limits check) yields exactly one result on the output channel. Most events
// step through accept, decide and commit before the next request is accepted;
// a new request is never taken while one is in flight. A work run that scales
// by load also runs the load sequence: elapsed and idle differences, the busy
// share, two decimal load digits of four restoring compare-and-subtract steps
// each on a 68-bit remainder, a 22x7 multiply, and a reciprocal multiply that
// divides by 100. When elapsed time is zero or no idle time has passed the
// digits are skipped. A finished result sits in an output register, and the
// commit of the next request waits only while that register is still full.
// Registers are to be written over APB at byte address 4*index only while
// no request is in flight; the block itself does not enforce this.
`default_nettype none

module load_based_dvfs_governor_unit import ldg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// APB configuration
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	// Event requests
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [ModeW-1:0] mode,
	input  wire logic [TimeW-1:0] idle_us,
	input  wire logic [TimeW-1:0] wall_us,
	input  wire logic [RunW-1:0]  runnable,
	input  wire logic [FreqW-1:0] cur_freq_khz,
	input  wire logic             suspend_flag,
	// Actions
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [ActW-1:0]  action,
	output logic      [FreqW-1:0] freq_khz,
	output logic                  relation
);

	cfg_t       cfg;
	ctrl_cmd_t  cmd;
	dp_status_t status;

	ldg_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ldg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	ldg_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.mode         (mode),
		.idle_us      (idle_us),
		.wall_us      (wall_us),
		.runnable     (runnable),
		.cur_freq_khz (cur_freq_khz),
		.suspend_flag (suspend_flag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.freq_khz     (freq_khz),
		.relation     (relation)
	);

	// One request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in flight");

	// Never overwrite a result that has not been taken
	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("result committed over a pending result");

	// Only a set action carries a floor relation
	a_rel_only_on_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (action != ACT_SET)) |-> (relation == REL_CEIL))
		else $error("relation set on a non-set action");

endmodule

`default_nettype wire
